FILE: sv/lpth_pkg.sv
// shared types and constants for the linear probing tuple hash table
package lpth_pkg;

  localparam int DEF_TABLE_SIZE = 1024;

  localparam int MODE_W = 2;
  localparam int VAR_W = 17;
  localparam int VAL_W = 17;
  localparam int CHILD_W = 25;
  localparam int KEY_W = VAR_W + VAL_W + 2 * CHILD_W;

  localparam int VAR_LSB = MODE_W;
  localparam int VAL_LSB = VAR_LSB + VAR_W;
  localparam int LEFT_LSB = VAL_LSB + VAL_W;
  localparam int RIGHT_LSB = LEFT_LSB + CHILD_W;
  localparam int IN_W = ((MODE_W + KEY_W + 7) / 8) * 8;

  localparam int SLOT_OUT_W = 10;
  localparam int STATUS_W = 2;
  localparam int OUT_W = ((SLOT_OUT_W + STATUS_W + 7) / 8) * 8;

  localparam int SUM_W = 26;
  localparam int MARK_W = 2;
  localparam int ENTRY_W = MARK_W + KEY_W;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_DELETED  = 2'd2
  } mark_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_PROBE,
    SRC_FREE
  } slot_src_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic      clear_step;
    logic      load;
    logic      set_home;
    logic      step;
    logic      take_free;
    logic      mem_write;
    logic      res_set;
    status_t   res_status;
    slot_src_t res_src;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_done;
    logic is_insert;
    logic is_remove;
    logic is_occ;
    logic is_empty;
    logic key_match;
    logic lap_end;
    logic have_free;
  } sts_t;

endpackage

FILE: sv/lpth_ctrl.sv
// controller state machine for the hash table
module lpth_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_ready,
  input  lpth_pkg::sts_t sts,
  output lpth_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_valid
);

  lpth_pkg::state_t state, state_next;
  logic out_valid_next;
  logic hit;
  logic more;
  logic out_free;

  assign hit = sts.is_occ & sts.key_match;
  assign more = ~sts.is_empty & ~sts.lap_end;
  assign out_free = ~out_valid | out_ready;
  assign in_ready = (state == lpth_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpth_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lpth_pkg::S_CLEAR: begin
        if (sts.clr_last) state_next = lpth_pkg::S_IDLE;
      end
      lpth_pkg::S_IDLE: begin
        if (in_valid) state_next = lpth_pkg::S_HASH;
      end
      lpth_pkg::S_HASH: begin
        if (sts.hash_done) state_next = lpth_pkg::S_READ;
      end
      lpth_pkg::S_READ: begin
        state_next = lpth_pkg::S_CHECK;
      end
      lpth_pkg::S_CHECK: begin
        if (sts.is_insert) begin
          if (hit) begin
            state_next = lpth_pkg::S_FINISH;
          end else if (!more) begin
            if (sts.have_free || !sts.is_occ) state_next = lpth_pkg::S_WRITE;
            else state_next = lpth_pkg::S_FINISH;
          end
        end else begin
          if (hit) begin
            if (sts.is_remove) state_next = lpth_pkg::S_WRITE;
            else state_next = lpth_pkg::S_FINISH;
          end else if (!more) begin
            state_next = lpth_pkg::S_FINISH;
          end
        end
      end
      lpth_pkg::S_WRITE: begin
        state_next = lpth_pkg::S_FINISH;
      end
      lpth_pkg::S_FINISH: begin
        if (out_free) state_next = lpth_pkg::S_IDLE;
      end
      default: state_next = lpth_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_status = lpth_pkg::ST_DONE;
    cmd.res_src = lpth_pkg::SRC_ZERO;
    case (state)
      lpth_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      lpth_pkg::S_IDLE: begin
        cmd.load = in_valid;
      end
      lpth_pkg::S_HASH: begin
        cmd.set_home = sts.hash_done;
      end
      lpth_pkg::S_READ: begin
      end
      lpth_pkg::S_CHECK: begin
        if (sts.is_insert) begin
          if (hit) begin
            cmd.res_set = 1'b1;
            cmd.res_status = lpth_pkg::ST_DUP;
            cmd.res_src = lpth_pkg::SRC_PROBE;
          end else begin
            cmd.take_free = ~sts.is_occ & ~sts.have_free;
            if (more) begin
              cmd.step = 1'b1;
            end else if (!sts.have_free && sts.is_occ) begin
              cmd.res_set = 1'b1;
              cmd.res_status = lpth_pkg::ST_FULL;
            end
          end
        end else begin
          if (hit) begin
            if (!sts.is_remove) begin
              cmd.res_set = 1'b1;
              cmd.res_src = lpth_pkg::SRC_PROBE;
            end
          end else if (more) begin
            cmd.step = 1'b1;
          end else begin
            cmd.res_set = 1'b1;
            cmd.res_status = lpth_pkg::ST_ABSENT;
          end
        end
      end
      lpth_pkg::S_WRITE: begin
        cmd.mem_write = 1'b1;
        cmd.res_set = 1'b1;
        cmd.res_src = sts.is_insert ? lpth_pkg::SRC_FREE : lpth_pkg::SRC_PROBE;
      end
      lpth_pkg::S_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/lpth_dp.sv
// datapath: hash unit, probe pointer, slot memory and result registers
module lpth_dp #(
  parameter int TABLE_SIZE = lpth_pkg::DEF_TABLE_SIZE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lpth_pkg::IN_W-1:0] in_data,
  input  lpth_pkg::cmd_t            cmd,
  output lpth_pkg::sts_t            sts,
  output logic [lpth_pkg::OUT_W-1:0] out_data
);

  localparam int SLOT_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam bit TS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

  logic [lpth_pkg::VAR_W-1:0]   f_var;
  logic [lpth_pkg::VAL_W-1:0]   f_val;
  logic [lpth_pkg::CHILD_W-1:0] f_left;
  logic [lpth_pkg::CHILD_W-1:0] f_right;
  logic [lpth_pkg::SUM_W-1:0]   sum_in;

  logic [lpth_pkg::MODE_W-1:0] mode;
  logic [lpth_pkg::KEY_W-1:0]  key;
  logic [SLOT_W-1:0] home;
  logic              hash_done;
  logic [SLOT_W-1:0] k;
  logic [SLOT_W-1:0] k_inc;
  logic [SLOT_W-1:0] free_slot;
  logic              have_free;
  logic [SLOT_W-1:0] clr;

  logic [lpth_pkg::ENTRY_W-1:0] mem [TABLE_SIZE];
  logic [lpth_pkg::ENTRY_W-1:0] rdata;
  logic [SLOT_W-1:0]            rd_addr;
  logic [SLOT_W-1:0]            wr_addr;
  logic [lpth_pkg::ENTRY_W-1:0] wr_data;
  logic                         wr_en;
  lpth_pkg::mark_t              rd_mark;
  lpth_pkg::mark_t              wr_mark;

  logic [SLOT_W-1:0]                 res_slot;
  lpth_pkg::status_t                 res_status;
  logic [lpth_pkg::SLOT_OUT_W+SLOT_W-1:0] slot_ext;
  logic [lpth_pkg::SLOT_OUT_W-1:0]   out_slot;
  lpth_pkg::status_t                 out_status;

  assign f_var = in_data[lpth_pkg::VAR_LSB +: lpth_pkg::VAR_W];
  assign f_val = in_data[lpth_pkg::VAL_LSB +: lpth_pkg::VAL_W];
  assign f_left = in_data[lpth_pkg::LEFT_LSB +: lpth_pkg::CHILD_W];
  assign f_right = in_data[lpth_pkg::RIGHT_LSB +: lpth_pkg::CHILD_W];

  // only non-negative fields go into the hash
  assign sum_in = (f_var[lpth_pkg::VAR_W-1] ? '0 : lpth_pkg::SUM_W'(f_var))
                + (f_val[lpth_pkg::VAL_W-1] ? '0 : lpth_pkg::SUM_W'(f_val))
                + (f_left[lpth_pkg::CHILD_W-1] ? '0 : lpth_pkg::SUM_W'(f_left))
                + (f_right[lpth_pkg::CHILD_W-1] ? '0 : lpth_pkg::SUM_W'(f_right));

  generate
    if (TS_POW2) begin : g_hash_mask
      logic [SLOT_W-1:0] home_r;
      always_ff @(posedge clk) begin
        if (cmd.load) home_r <= sum_in[SLOT_W-1:0];
      end
      assign home = home_r;
      assign hash_done = 1'b1;
    end else begin : g_hash_recip
      localparam int RECIP = (1 << lpth_pkg::SUM_W) / TABLE_SIZE;
      logic [lpth_pkg::SUM_W-1:0]   sum_r;
      logic [lpth_pkg::SUM_W-1:0]   quo;
      logic [lpth_pkg::SUM_W-1:0]   diff;
      logic [1:0]                   cnt;
      logic [2*lpth_pkg::SUM_W-1:0] prod;
      logic [lpth_pkg::SUM_W-1:0]   quo_ts;
      // reciprocal quotient is low by at most one, so one subtract fixes the remainder
      assign prod = (2*lpth_pkg::SUM_W)'(sum_r) * (2*lpth_pkg::SUM_W)'(RECIP);
      assign quo_ts = quo * lpth_pkg::SUM_W'(TABLE_SIZE);
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          sum_r <= sum_in;
          cnt <= 2'd2;
        end else if (cnt != '0) begin
          cnt <= cnt - 1'b1;
          if (cnt == 2'd2) quo <= prod[2*lpth_pkg::SUM_W-1 -: lpth_pkg::SUM_W];
          else diff <= sum_r - quo_ts;
        end
      end
      assign home = (diff >= lpth_pkg::SUM_W'(TABLE_SIZE))
                  ? SLOT_W'(diff - lpth_pkg::SUM_W'(TABLE_SIZE)) : diff[SLOT_W-1:0];
      assign hash_done = (cnt == '0);
    end
  endgenerate

  assign k_inc = (k == SLOT_W'(TABLE_SIZE - 1)) ? '0 : k + 1'b1;
  assign rd_addr = cmd.step ? k_inc : k;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= in_data[lpth_pkg::MODE_W-1:0];
      key <= in_data[lpth_pkg::VAR_LSB +: lpth_pkg::KEY_W];
      have_free <= 1'b0;
    end else if (cmd.take_free) begin
      have_free <= 1'b1;
    end
    if (cmd.take_free) free_slot <= k;
    if (cmd.set_home) begin
      k <= home;
    end else if (cmd.step) begin
      k <= k_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear_step) begin
      clr <= clr + 1'b1;
    end
  end

  assign wr_mark = (mode == lpth_pkg::MODE_INSERT) ? lpth_pkg::MARK_OCCUPIED
                                                   : lpth_pkg::MARK_DELETED;
  assign wr_en = cmd.mem_write | cmd.clear_step;
  always_comb begin
    if (cmd.clear_step) begin
      wr_addr = clr;
      wr_data = '0;
    end else begin
      wr_addr = (mode == lpth_pkg::MODE_INSERT) ? free_slot : k;
      wr_data = {wr_mark, key};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  assign rd_mark = lpth_pkg::mark_t'(rdata[lpth_pkg::KEY_W +: lpth_pkg::MARK_W]);

  always_comb begin
    sts.clr_last = (clr == SLOT_W'(TABLE_SIZE - 1));
    sts.hash_done = hash_done;
    sts.is_insert = (mode == lpth_pkg::MODE_INSERT);
    sts.is_remove = (mode == lpth_pkg::MODE_REMOVE);
    sts.is_occ = (rd_mark == lpth_pkg::MARK_OCCUPIED);
    sts.is_empty = (rd_mark == lpth_pkg::MARK_EMPTY);
    sts.key_match = (rdata[lpth_pkg::KEY_W-1:0] == key);
    sts.lap_end = (k_inc == home);
    sts.have_free = have_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      case (cmd.res_src)
        lpth_pkg::SRC_PROBE: res_slot <= k;
        lpth_pkg::SRC_FREE:  res_slot <= free_slot;
        default:             res_slot <= '0;
      endcase
    end
  end

  assign slot_ext = {{lpth_pkg::SLOT_OUT_W{1'b0}}, res_slot};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot <= slot_ext[lpth_pkg::SLOT_OUT_W-1:0];
      out_status <= res_status;
    end
  end

  assign out_data = {{(lpth_pkg::OUT_W - lpth_pkg::SLOT_OUT_W - lpth_pkg::STATUS_W){1'b0}},
                     out_status, out_slot};

endmodule

FILE: sv/linear_probe_tuple_hash_table.sv
// top level of the linear probing tuple hash table
// Open-addressing table of four-field keys with insert, remove and lookup requests, one
// result per request. After reset the block sweeps the slot memory clear, one slot a cycle,
// before it takes its first request. A request is then loaded, hashed, read and checked,
// probing one slot a cycle through the single read port of the slot memory, and a
// successful insert or remove adds a memory write. For a TABLE_SIZE that is not a power of
// two the hash remainder is found by a reciprocal multiply and one correcting subtract, with
// the quotient and then the difference registered before the home slot is formed. A finished
// result waits in the output register while the next request is taken; a request holds in
// its last cycle while that register still holds an unaccepted result.
module linear_probe_tuple_hash_table #(
  parameter int TABLE_SIZE = lpth_pkg::DEF_TABLE_SIZE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // mode, var_id, value, left_child, right_child, zero pad
  input  logic [lpth_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // slot, status, zero pad
  output logic [lpth_pkg::OUT_W-1:0] m_tdata
);

  lpth_pkg::cmd_t cmd;
  lpth_pkg::sts_t sts;

  lpth_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  lpth_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (m_tdata)
  );

endmodule

FILE: verif/linear_probe_tuple_hash_table_check.sv
// checker that predicts and compares every result of the linear probing tuple hash table
`timescale 1ns / 100ps

module linear_probe_tuple_hash_table_check #(
  parameter int TABLE_SIZE = lpth_pkg::DEF_TABLE_SIZE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [lpth_pkg::IN_W-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [lpth_pkg::OUT_W-1:0] m_tdata,
  output int                         mismatches,
  output int                         outstanding
);
  import lpth_pkg::*;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    status_t               status;
  } outcome_t;

  mark_t            slot_mark [TABLE_SIZE];
  logic [KEY_W-1:0] slot_key [TABLE_SIZE];
  outcome_t         awaited_outcomes [$];
  outcome_t         want;
  logic [SLOT_OUT_W-1:0] got_slot;
  logic [STATUS_W-1:0]   got_status;
  int bad_results;
  int open_requests;

  assign mismatches = bad_results;
  assign outstanding = open_requests;

  function automatic outcome_t apply_request(input logic [MODE_W-1:0] mode,
                                             input logic [KEY_W-1:0] key);
    logic [SUM_W-1:0] total;
    int home;
    int k;
    int free_slot;
    bit have_free;
    mark_t cur;
    outcome_t res;
    total = '0;
    // absent (negative) fields do not count toward the home slot
    if (!key[VAR_W-1]) total += key[0 +: VAR_W];
    if (!key[VAR_W+VAL_W-1]) total += key[VAR_W +: VAL_W];
    if (!key[VAR_W+VAL_W+CHILD_W-1]) total += key[VAR_W+VAL_W +: CHILD_W];
    if (!key[KEY_W-1]) total += key[VAR_W+VAL_W+CHILD_W +: CHILD_W];
    home = total % TABLE_SIZE;
    k = home;
    have_free = 1'b0;
    free_slot = 0;
    res.slot = '0;
    res.status = ST_ABSENT;
    if (mode == MODE_INSERT) begin
      do begin
        cur = slot_mark[k];
        if (cur != MARK_OCCUPIED) begin
          if (!have_free) begin
            have_free = 1'b1;
            free_slot = k;
          end
        end else if (slot_key[k] == key) begin
          res.slot = k[SLOT_OUT_W-1:0];
          res.status = ST_DUP;
          return res;
        end
        k = (k + 1) % TABLE_SIZE;
      end while (cur != MARK_EMPTY && k != home);
      if (!have_free) begin
        res.status = ST_FULL;
        return res;
      end
      slot_key[free_slot] = key;
      slot_mark[free_slot] = MARK_OCCUPIED;
      res.slot = free_slot[SLOT_OUT_W-1:0];
      res.status = ST_DONE;
      return res;
    end
    // remove and lookup share the search
    do begin
      cur = slot_mark[k];
      if (cur == MARK_OCCUPIED && slot_key[k] == key) begin
        if (mode == MODE_REMOVE) slot_mark[k] = MARK_DELETED;
        res.slot = k[SLOT_OUT_W-1:0];
        res.status = ST_DONE;
        return res;
      end
      k = (k + 1) % TABLE_SIZE;
    end while (cur != MARK_EMPTY && k != home);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_mark[i]) slot_mark[i] = MARK_EMPTY;
      awaited_outcomes.delete();
      bad_results = 0;
      open_requests = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_slot = m_tdata[0 +: SLOT_OUT_W];
        got_status = m_tdata[SLOT_OUT_W +: STATUS_W];
        if (awaited_outcomes.size() == 0) begin
          $error("unexpected result: slot %0d status %0d", got_slot, got_status);
          bad_results++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got_slot != want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, got_slot);
            bad_results++;
          end
          if (got_status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            bad_results++;
          end
        end
      end
      if (s_tvalid && s_tready)
        awaited_outcomes.push_back(apply_request(s_tdata[0 +: MODE_W],
                                                 s_tdata[VAR_LSB +: KEY_W]));
      open_requests = awaited_outcomes.size();
    end
  end

endmodule

FILE: verif/linear_probe_tuple_hash_table_test.sv
// stimulus and verdict for the linear probing tuple hash table
`timescale 1ns / 100ps

module linear_probe_tuple_hash_table_test;
  import lpth_pkg::*;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int FILL_COUNT = 1100;

  typedef struct packed {
    logic signed [CHILD_W-1:0] right_child;
    logic signed [CHILD_W-1:0] left_child;
    logic signed [VAL_W-1:0]   value;
    logic signed [VAR_W-1:0]   var_id;
  } key_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  int mismatches;
  int outstanding;
  int stall_cycles;
  int delivered;
  bit tx_steady;
  bit rx_steady;
  key_t known [$];
  key_t ka, kb, kc, kd, ke, kz;

  linear_probe_tuple_hash_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  linear_probe_tuple_hash_table_check outcome_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int idle_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic key_t key_of(input int v, input int x, input int l, input int r);
    key_t k;
    k.var_id = v[VAR_W-1:0];
    k.value = x[VAL_W-1:0];
    k.left_child = l[CHILD_W-1:0];
    k.right_child = r[CHILD_W-1:0];
    return k;
  endfunction

  function automatic logic [CHILD_W-1:0] key_field(input int top);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '1;
    if (r < 4) return CHILD_W'($urandom_range(0, 15));
    if (r < 5) return CHILD_W'(top);
    return CHILD_W'($urandom_range(0, top));
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    k.var_id = VAR_W'(key_field(65535));
    k.value = VAL_W'(key_field(65535));
    k.left_child = key_field(16777215);
    k.right_child = key_field(16777215);
    return k;
  endfunction

  // keys that pile up near both ends of the table so probes chain and wrap
  function automatic key_t clustered_key();
    key_t k;
    k = key_of(-1, -1, -1, -1);
    k.var_id = VAR_W'($urandom_range(0, 1) ? $urandom_range(1010, 1023)
                                           : $urandom_range(0, 12));
    if ($urandom_range(0, 1)) k.left_child = CHILD_W'(1024 * $urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) k.value = VAL_W'($urandom_range(0, 3) * 1024);
    return k;
  endfunction

  task automatic send_request(input logic [MODE_W-1:0] mode, input key_t key);
    int gap;
    gap = idle_gap(tx_steady);
    repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_W-MODE_W-KEY_W){1'b0}}, key, mode};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic random_request(input int ins_pct, input int rem_pct);
    int r;
    key_t k;
    logic [MODE_W-1:0] mode;
    r = $urandom_range(0, 99);
    if (known.size() > 0 && $urandom_range(0, 9) < 7) begin
      k = known[$urandom_range(0, known.size() - 1)];
    end else begin
      k = ($urandom_range(0, 2) == 0) ? clustered_key() : fresh_key();
      known.push_back(k);
    end
    if (r < ins_pct) mode = MODE_INSERT;
    else if (r < ins_pct + rem_pct) mode = MODE_REMOVE;
    else if (r < 97) mode = MODE_LOOKUP;
    else mode = MODE_SPARE;
    send_request(mode, k);
  endtask

  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    wait (outstanding == 0);
  endtask

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result side, with one long hold-off so the request side backs up
  initial begin
    m_tready = 1'b0;
    delivered = 0;
    rx_steady = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (delivered == 40) begin
        repeat (HOLD_CYCLES) @(negedge clk) m_tready <= 1'b0;
      end else begin
        repeat (idle_gap(rx_steady)) @(negedge clk) m_tready <= 1'b0;
      end
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      delivered++;
      if (delivered % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    tx_steady = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    ka = key_of(65535, 65535, 16777215, 16777215);
    ke = key_of(-1, 1020, -1, -1);
    kc = key_of(1023, -1, -1, -1);
    kd = key_of(-1, 1023, -1, -1);
    kb = key_of(-1, -1, -1, -1);
    kz = key_of(0, 0, 0, 0);
    send_request(MODE_LOOKUP, kb);
    send_request(MODE_REMOVE, kb);
    send_request(MODE_INSERT, ka);
    send_request(MODE_INSERT, ka);
    send_request(MODE_INSERT, ke);
    send_request(MODE_LOOKUP, ke);
    send_request(MODE_INSERT, kc);
    send_request(MODE_INSERT, kd);
    send_request(MODE_INSERT, kb);
    send_request(MODE_INSERT, kz);
    send_request(MODE_SPARE, kz);
    send_request(MODE_REMOVE, ka);
    send_request(MODE_LOOKUP, ka);
    send_request(MODE_LOOKUP, ke);
    send_request(MODE_INSERT, ke);
    send_request(MODE_INSERT, ka);
    send_request(MODE_REMOVE, kd);
    send_request(MODE_REMOVE, kd);
    send_request(MODE_INSERT, kz);
    send_request(MODE_INSERT, kd);
    send_request(MODE_INSERT, key_of(5, -1, 7, -1));
    send_request(MODE_INSERT, key_of(-1, 5, -1, 7));
    send_request(MODE_LOOKUP, key_of(-1, 5, -1, 7));
    known.push_back(ka);
    known.push_back(kb);
    known.push_back(kc);
    known.push_back(kd);
    known.push_back(ke);
    known.push_back(kz);
    drain();

    tx_steady = 1'b0;
    for (int i = 0; i < 300; i++) begin
      random_request(45, 25);
    end
    drain();

    // distinct inserts well past the table size, so the table ends up full
    for (int i = 0; i < FILL_COUNT; i++) begin
      key_t k;
      k = fresh_key();
      k.var_id = VAR_W'(i);
      known.push_back(k);
      tx_steady = (i < FILL_COUNT / 2);
      send_request(MODE_INSERT, k);
    end
    drain();

    tx_steady = 1'b0;
    for (int i = 0; i < 200; i++) begin
      random_request(30, 35);
    end
    drain();

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lpth_pkg.sv
sv/lpth_ctrl.sv
sv/lpth_dp.sv
sv/linear_probe_tuple_hash_table.sv
verif/linear_probe_tuple_hash_table_check.sv
verif/linear_probe_tuple_hash_table_test.sv
